/* src/cmc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmc_pkg
// Shared types, opcodes, face-turn tables and the D3 orientation rule for the
// cubie-level cube move engine.
// ----------------------------------------------------------------------------
package cmc_pkg;

  localparam int NCORN = 8;
  localparam int NEDGE = 12;
  localparam int NFACE = 6;

  // Opcodes of the operation field
  localparam logic [1:0] OP_TURN = 2'd0;
  localparam logic [1:0] OP_MUL  = 2'd1;
  localparam logic [1:0] OP_LOAD = 2'd2;
  localparam logic [1:0] OP_INV  = 2'd3;

  typedef logic [NCORN-1:0][5:0] corners_t;  // per slot: {ori[2:0], cubie[2:0]}
  typedef logic [NEDGE-1:0][4:0] edges_t;    // per slot: {flip, cubie[3:0]}

  typedef enum logic [1:0] {
    CMD_MUL,   // right-multiply state by operand cube
    CMD_LOAD,  // replace state with operand cube
    CMD_INV,   // invert state
    CMD_HOLD   // keep state (null turn or rejected word)
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic      bad;
    corners_t  corners;
    edges_t    edges;
  } cmd_t;

  localparam logic [2:0] FACE_CC [NFACE][NCORN] = '{
    '{3'd3, 3'd0, 3'd1, 3'd2, 3'd4, 3'd5, 3'd6, 3'd7},
    '{3'd4, 3'd1, 3'd2, 3'd0, 3'd7, 3'd5, 3'd6, 3'd3},
    '{3'd1, 3'd5, 3'd2, 3'd3, 3'd0, 3'd4, 3'd6, 3'd7},
    '{3'd0, 3'd1, 3'd2, 3'd3, 3'd5, 3'd6, 3'd7, 3'd4},
    '{3'd0, 3'd2, 3'd6, 3'd3, 3'd4, 3'd1, 3'd5, 3'd7},
    '{3'd0, 3'd1, 3'd3, 3'd7, 3'd4, 3'd5, 3'd2, 3'd6}};

  localparam logic [2:0] FACE_CO [NFACE][NCORN] = '{
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd2, 3'd0, 3'd0, 3'd1, 3'd1, 3'd0, 3'd0, 3'd2},
    '{3'd1, 3'd2, 3'd0, 3'd0, 3'd2, 3'd1, 3'd0, 3'd0},
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd1, 3'd2, 3'd0, 3'd0, 3'd2, 3'd1, 3'd0},
    '{3'd0, 3'd0, 3'd1, 3'd2, 3'd0, 3'd0, 3'd2, 3'd1}};

  localparam logic [3:0] FACE_EC [NFACE][NEDGE] = '{
    '{4'd3, 4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11},
    '{4'd8, 4'd1, 4'd2, 4'd3, 4'd11, 4'd5, 4'd6, 4'd7, 4'd4, 4'd9, 4'd10, 4'd0},
    '{4'd0, 4'd9, 4'd2, 4'd3, 4'd4, 4'd8, 4'd6, 4'd7, 4'd1, 4'd5, 4'd10, 4'd11},
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd4, 4'd8, 4'd9, 4'd10, 4'd11},
    '{4'd0, 4'd1, 4'd10, 4'd3, 4'd4, 4'd5, 4'd9, 4'd7, 4'd8, 4'd2, 4'd6, 4'd11},
    '{4'd0, 4'd1, 4'd2, 4'd11, 4'd4, 4'd5, 4'd6, 4'd10, 4'd8, 4'd9, 4'd3, 4'd7}};

  localparam logic FACE_EO [NFACE][NEDGE] = '{
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1}};

  // D3 composition; 0..2 are rotations, 3..5 mirrored
  function automatic logic [2:0] d3_compose(input logic [2:0] oa, input logic [2:0] ob);
    logic [3:0] sum;
    logic [3:0] diff;
    logic [3:0] r;
    sum  = {1'b0, oa} + {1'b0, ob};
    diff = {1'b0, oa} - {1'b0, ob};
    if (oa < 3'd3 && ob < 3'd3) begin
      r = (sum >= 4'd3) ? sum - 4'd3 : sum;
    end else if (oa < 3'd3) begin
      r = (sum >= 4'd6) ? sum - 4'd3 : sum;
    end else if (ob < 3'd3) begin
      r = (diff < 4'd3) ? diff + 4'd3 : diff;
    end else begin
      // diff[3] marks a negative difference
      r = diff[3] ? diff + 4'd3 : diff;
    end
    return r[2:0];
  endfunction

endpackage

/* src/cmc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmc_front
// Input side: decodes a beat, validates supplied cubes and expands face turns
// into an operand cube, then pushes one command into the queue.
// ----------------------------------------------------------------------------
module cmc_front (
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [119:0]   s_tdata,
  input  logic           q_full,
  output logic           push,
  output cmc_pkg::cmd_t  cmd
);

  logic [1:0]        operation;
  logic [2:0]        axis;
  logic [1:0]        quarter_turns;
  cmc_pkg::corners_t corner_word;
  cmc_pkg::edges_t   edge_word;

  logic [2:0]        ax;
  cmc_pkg::corners_t fc;
  cmc_pkg::corners_t fc_step;
  cmc_pkg::edges_t   fe;
  cmc_pkg::edges_t   fe_step;
  logic [7:0]        cseen;
  logic [11:0]       eseen;
  logic              bad;

  assign operation     = s_tdata[1:0];
  assign axis          = s_tdata[4:2];
  assign quarter_turns = s_tdata[6:5];
  assign corner_word   = s_tdata[54:7];
  assign edge_word     = s_tdata[114:55];

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  // supplied cube check
  always_comb begin
    cseen = '0;
    eseen = '0;
    bad   = 1'b0;
    for (int i = 0; i < cmc_pkg::NCORN; i++) begin
      cseen = cseen | (8'd1 << corner_word[i][2:0]);
      if (corner_word[i][5:3] > 3'd5) bad = 1'b1;
    end
    for (int k = 0; k < cmc_pkg::NEDGE; k++) begin
      if (edge_word[k][3:0] >= 4'(cmc_pkg::NEDGE)) bad = 1'b1;
      else eseen = eseen | (12'd1 << edge_word[k][3:0]);
    end
    if (cseen != 8'hFF)   bad = 1'b1;
    if (eseen != 12'hFFF) bad = 1'b1;
  end

  // face turn cube: identity composed with the face cube up to three times
  always_comb begin
    ax = (axis < 3'(cmc_pkg::NFACE)) ? axis : 3'd0;
    for (int i = 0; i < cmc_pkg::NCORN; i++) fc[i] = {3'd0, 3'(i)};
    for (int k = 0; k < cmc_pkg::NEDGE; k++) fe[k] = {1'b0, 4'(k)};
    fc_step = fc;
    fe_step = fe;
    for (int t = 0; t < 3; t++) begin
      for (int i = 0; i < cmc_pkg::NCORN; i++) begin
        fc_step[i] = {cmc_pkg::d3_compose(fc[cmc_pkg::FACE_CC[ax][i]][5:3],
                                          cmc_pkg::FACE_CO[ax][i]),
                      fc[cmc_pkg::FACE_CC[ax][i]][2:0]};
      end
      for (int k = 0; k < cmc_pkg::NEDGE; k++) begin
        fe_step[k] = {fe[cmc_pkg::FACE_EC[ax][k]][4] ^ cmc_pkg::FACE_EO[ax][k],
                      fe[cmc_pkg::FACE_EC[ax][k]][3:0]};
      end
      if (2'(t) < quarter_turns) begin
        fc = fc_step;
        fe = fe_step;
      end
    end
  end

  always_comb begin
    cmd.kind    = cmc_pkg::CMD_HOLD;
    cmd.bad     = 1'b0;
    cmd.corners = corner_word;
    cmd.edges   = edge_word;
    case (operation)
      cmc_pkg::OP_TURN: begin
        if (axis < 3'(cmc_pkg::NFACE) && quarter_turns != 2'd0) begin
          cmd.kind    = cmc_pkg::CMD_MUL;
          cmd.corners = fc;
          cmd.edges   = fe;
        end
      end
      cmc_pkg::OP_MUL: begin
        cmd.kind = bad ? cmc_pkg::CMD_HOLD : cmc_pkg::CMD_MUL;
        cmd.bad  = bad;
      end
      cmc_pkg::OP_LOAD: begin
        cmd.kind = bad ? cmc_pkg::CMD_HOLD : cmc_pkg::CMD_LOAD;
        cmd.bad  = bad;
      end
      cmc_pkg::OP_INV: begin
        cmd.kind = cmc_pkg::CMD_INV;
      end
      default: begin
        cmd.kind = cmc_pkg::CMD_HOLD;
      end
    endcase
  end

endmodule

/* src/cmc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmc_queue
// Two-entry command queue between the front and back sides.
// ----------------------------------------------------------------------------
module cmc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cmc_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output cmc_pkg::cmd_t  head
);

  cmc_pkg::cmd_t mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/cmc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmc_back
// Execution side: holds the cube state, runs one command per cycle while the
// output is free or taken and registers the packed state as the result beat.
// ----------------------------------------------------------------------------
module cmc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  cmc_pkg::cmd_t  q_cmd,
  output logic           pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [111:0]   m_tdata
);

  cmc_pkg::corners_t corner_st;
  cmc_pkg::edges_t   edge_st;
  cmc_pkg::corners_t corner_next;
  cmc_pkg::edges_t   edge_next;
  cmc_pkg::corners_t mul_c;
  cmc_pkg::edges_t   mul_e;
  cmc_pkg::corners_t inv_c;
  cmc_pkg::edges_t   inv_e;
  logic [3:0]        esrc;
  logic [2:0]        inv_o;

  assign pop = q_valid && (!m_tvalid || m_tready);

  // state * operand
  always_comb begin
    esrc = '0;
    for (int i = 0; i < cmc_pkg::NCORN; i++) begin
      mul_c[i] = {cmc_pkg::d3_compose(corner_st[q_cmd.corners[i][2:0]][5:3],
                                      q_cmd.corners[i][5:3]),
                  corner_st[q_cmd.corners[i][2:0]][2:0]};
    end
    for (int k = 0; k < cmc_pkg::NEDGE; k++) begin
      esrc = (q_cmd.edges[k][3:0] >= 4'(cmc_pkg::NEDGE)) ? 4'd0 : q_cmd.edges[k][3:0];
      mul_e[k] = {edge_st[esrc][4] ^ q_cmd.edges[k][4], edge_st[esrc][3:0]};
    end
  end

  // inverse: slot j gets the slot that holds cubie j
  always_comb begin
    inv_o = '0;
    for (int j = 0; j < cmc_pkg::NCORN; j++) begin
      inv_c[j] = '0;
      for (int i = 0; i < cmc_pkg::NCORN; i++) begin
        if (corner_st[i][2:0] == 3'(j)) inv_c[j] = {corner_st[i][5:3], 3'(i)};
      end
      inv_o = inv_c[j][5:3];
      // mirrored orientations stay, rotations are negated mod 3
      if (inv_o == 3'd1)      inv_c[j][5:3] = 3'd2;
      else if (inv_o == 3'd2) inv_c[j][5:3] = 3'd1;
    end
    for (int j = 0; j < cmc_pkg::NEDGE; j++) begin
      inv_e[j] = '0;
      for (int i = 0; i < cmc_pkg::NEDGE; i++) begin
        if (edge_st[i][3:0] == 4'(j)) inv_e[j] = {edge_st[i][4], 4'(i)};
      end
    end
  end

  always_comb begin
    corner_next = corner_st;
    edge_next   = edge_st;
    case (q_cmd.kind)
      cmc_pkg::CMD_MUL: begin
        corner_next = mul_c;
        edge_next   = mul_e;
      end
      cmc_pkg::CMD_LOAD: begin
        corner_next = q_cmd.corners;
        edge_next   = q_cmd.edges;
      end
      cmc_pkg::CMD_INV: begin
        corner_next = inv_c;
        edge_next   = inv_e;
      end
      default: begin
        corner_next = corner_st;
        edge_next   = edge_st;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cmc_pkg::NCORN; i++) corner_st[i] <= {3'd0, 3'(i)};
      for (int k = 0; k < cmc_pkg::NEDGE; k++) edge_st[k] <= {1'b0, 4'(k)};
      m_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        corner_st <= corner_next;
        edge_st   <= edge_next;
        m_tvalid  <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) m_tdata <= {3'd0, q_cmd.bad, edge_next, corner_next};
  end

endmodule

/* src/cubie_cube_move_engine_core.sv */
`timescale 1ns / 1ps
// An accepted input beat is queued, then its result is registered onto m_*.
// Throughput: one beat per cycle while m_tready keeps m_* draining; each
//   command is one compose/invert crossbar pass on the state register.
// Reset (rst, synchronous, active high): cube state returns to the solved
//   identity, command queue and output register are emptied.
// ----------------------------------------------------------------------------
// cubie_cube_move_engine_core
// Cubie-level 3x3x3 cube move engine: face turns, multiply, load, invert.
// ----------------------------------------------------------------------------
module cubie_cube_move_engine_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // operation[1:0], axis[4:2], quarter_turns[6:5], corner_word[54:7],
  // edge_word[114:55], zero pad[119:115]
  input  logic [119:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // corner_state[47:0], edge_state[107:48], bad_word[108], zero pad[111:109]
  output logic [111:0] m_tdata
);

  cmc_pkg::cmd_t front_cmd;
  cmc_pkg::cmd_t head_cmd;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_valid;

  cmc_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .push     (push),
    .cmd      (front_cmd)
  );

  cmc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .head      (head_cmd)
  );

  cmc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (head_cmd),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
